### hw/rtl/chc_pkg.sv
// Package with the shared types, widths and arctangent table of the compass heading pipeline.
`default_nettype none

package chc_pkg;

    localparam int IN_W            = 16;
    localparam int ABS_W           = IN_W + 1;
    localparam int VEC_SCALE_BITS  = 20;
    localparam int VEC_W           = ABS_W + VEC_SCALE_BITS + 1;
    localparam int ANGLE_W         = 32;
    localparam int Z_W             = ANGLE_W + 1;
    localparam int CLAMP_W         = ANGLE_W - 1;
    localparam int HEAD_ANGLE_W    = ANGLE_W + 1;
    localparam int OUT_W           = 16;
    localparam int CD_W            = OUT_W + 1;
    localparam int PROD_W          = HEAD_ANGLE_W + OUT_W;

    localparam int ATAN_TABLE_LEN  = 24;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    localparam logic [CLAMP_W-1:0]      QUARTER_TURN  = CLAMP_W'(64'd1073741824);
    localparam logic [HEAD_ANGLE_W-1:0] QUARTER_H     = HEAD_ANGLE_W'(64'd1073741824);
    localparam logic [HEAD_ANGLE_W-1:0] THREE_QUARTER = HEAD_ANGLE_W'(64'd3221225472);
    localparam logic [OUT_W-1:0]        HEADING_FULL  = OUT_W'(36000);
    localparam logic [OUT_W-1:0]        HEADING_HALF  = OUT_W'(18000);
    localparam logic [OUT_W-1:0]        HEADING_ZERO  = '0;

    localparam logic [ANGLE_W-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic y_zero;
        logic y_neg;
        logic x_zero;
        logic x_neg;
    } chc_flags_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } chc_vec_t;

endpackage

`default_nettype wire

### hw/rtl/chc_prep.sv
// Input stage: magnitudes of the sample pair, quadrant flags and the starting CORDIC vector.
`default_nettype none

module chc_prep (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [chc_pkg::IN_W-1:0]   x_field,
    input  wire logic signed [chc_pkg::IN_W-1:0]   y_field,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output chc_pkg::chc_vec_t                      out_vec,
    output chc_pkg::chc_flags_t                    out_flags
);
    import chc_pkg::*;

    logic                     valid_reg;
    chc_vec_t                 vec_reg;
    chc_vec_t                 vec_next;
    chc_flags_t               flags_reg;
    chc_flags_t               flags_next;
    logic signed [ABS_W-1:0]  x_ext;
    logic signed [ABS_W-1:0]  y_ext;
    logic        [ABS_W-1:0]  x_abs;
    logic        [ABS_W-1:0]  y_abs;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        x_ext = ABS_W'(x_field);
        y_ext = ABS_W'(y_field);
        x_abs = x_field[IN_W-1] ? ABS_W'(-x_ext) : ABS_W'(x_ext);
        y_abs = y_field[IN_W-1] ? ABS_W'(-y_ext) : ABS_W'(y_ext);
        vec_next.x = {1'b0, y_abs, {VEC_SCALE_BITS{1'b0}}};
        vec_next.y = {1'b0, x_abs, {VEC_SCALE_BITS{1'b0}}};
        vec_next.z = '0;
        flags_next.y_zero = (y_field == '0);
        flags_next.y_neg  = y_field[IN_W-1];
        flags_next.x_zero = (x_field == '0);
        flags_next.x_neg  = x_field[IN_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg   <= vec_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

### hw/rtl/chc_cordic_stage.sv
// One registered vectoring CORDIC iteration with a fixed shift and table angle.
`default_nettype none

module chc_cordic_stage #(
    parameter int STAGE_IDX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire chc_pkg::chc_vec_t    in_vec,
    input  wire chc_pkg::chc_flags_t  in_flags,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output chc_pkg::chc_vec_t         out_vec,
    output chc_pkg::chc_flags_t       out_flags
);
    import chc_pkg::*;

    localparam logic signed [Z_W-1:0] STEP_ANGLE = $signed({1'b0, ATAN_TABLE[STAGE_IDX]});

    logic                     valid_reg;
    chc_vec_t                 vec_reg;
    chc_vec_t                 vec_next;
    chc_flags_t               flags_reg;
    logic signed [VEC_W-1:0]  dx;
    logic signed [VEC_W-1:0]  dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        dx = in_vec.y >>> STAGE_IDX;
        dy = in_vec.x >>> STAGE_IDX;
        if (!in_vec.y[VEC_W-1]) begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + STEP_ANGLE;
        end else begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - STEP_ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg   <= vec_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

### hw/rtl/chc_post.sv
// Output stages: clamp and quadrant fold, scale to hundredths of a degree, round and wrap.
`default_nettype none

module chc_post (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire chc_pkg::chc_vec_t           in_vec,
    input  wire chc_pkg::chc_flags_t         in_flags,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [chc_pkg::OUT_W-1:0]        heading_centideg
);
    import chc_pkg::*;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ANGLE_W - 1);

    logic                     fold_valid_reg;
    logic [HEAD_ANGLE_W-1:0]  head_reg;
    logic [HEAD_ANGLE_W-1:0]  head_next;
    chc_flags_t               fold_flags_reg;
    logic [CLAMP_W-1:0]       clamp_angle;
    logic                     fold_ready;

    logic                     mul_valid_reg;
    logic [PROD_W-1:0]        prod_reg;
    chc_flags_t               mul_flags_reg;
    logic                     mul_ready;

    logic                     out_valid_reg;
    logic [OUT_W-1:0]         heading_reg;
    logic [OUT_W-1:0]         heading_next;
    logic [PROD_W-1:0]        rounded;
    logic [CD_W-1:0]          cd;
    logic                     out_en;

    assign out_en     = !out_valid_reg || out_ready;
    assign mul_ready  = !mul_valid_reg || out_en;
    assign fold_ready = !fold_valid_reg || mul_ready;
    assign in_ready   = fold_ready;

    always_comb begin
        if (in_vec.z[Z_W-1]) begin
            clamp_angle = '0;
        end else if (in_vec.z > $signed({2'b00, QUARTER_TURN})) begin
            clamp_angle = QUARTER_TURN;
        end else begin
            clamp_angle = CLAMP_W'(in_vec.z);
        end
        if (in_flags.x_zero) begin
            clamp_angle = '0;
        end
        if (!in_flags.y_neg) begin
            head_next = in_flags.x_neg ? QUARTER_H + HEAD_ANGLE_W'(clamp_angle)
                                       : QUARTER_H - HEAD_ANGLE_W'(clamp_angle);
        end else begin
            head_next = (!in_flags.x_neg && !in_flags.x_zero)
                      ? THREE_QUARTER + HEAD_ANGLE_W'(clamp_angle)
                      : THREE_QUARTER - HEAD_ANGLE_W'(clamp_angle);
        end
    end

    always_comb begin
        rounded = prod_reg + ROUND_HALF;
        cd      = rounded[PROD_W-1 -: CD_W];
        if (cd >= CD_W'(HEADING_FULL)) begin
            cd = cd - CD_W'(HEADING_FULL);
        end
        if (mul_flags_reg.y_zero) begin
            heading_next = mul_flags_reg.x_neg ? HEADING_HALF : HEADING_ZERO;
        end else begin
            heading_next = OUT_W'(cd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
            mul_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (fold_ready) begin
                fold_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                mul_valid_reg <= fold_valid_reg;
            end
            if (out_en) begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fold_ready && in_valid) begin
            head_reg       <= head_next;
            fold_flags_reg <= in_flags;
        end
        if (mul_ready && fold_valid_reg) begin
            prod_reg      <= head_reg * HEADING_FULL;
            mul_flags_reg <= fold_flags_reg;
        end
        if (out_en && mul_valid_reg) begin
            heading_reg <= heading_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign heading_centideg = heading_reg;

endmodule

`default_nettype wire

### hw/rtl/compass_heading_from_xy.sv
// Top level of the pipelined compass heading unit built on a vectoring CORDIC.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_x_field, s_y_field (signed 16 bit)
//   m_        out        m_valid/m_ready    m_heading_centideg (unsigned 16 bit)
//
// A beat passes one input register, ANGLE_ITERATIONS CORDIC stages (at most 24) and
// three output stages (fold, multiply, round) before its heading reaches m_heading_centideg.
// One beat is taken in every cycle while no stall on m_ready holds the pipeline.
// Reset clears the valid bits of all stages and nothing else.
// A stall on m_ready holds only the run of full stages back from the output; the rest keep filling.
`default_nettype none

module compass_heading_from_xy #(
    parameter int ANGLE_ITERATIONS = chc_pkg::ANGLE_ITERATIONS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [chc_pkg::IN_W-1:0]   s_x_field,
    input  wire logic signed [chc_pkg::IN_W-1:0]   s_y_field,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [chc_pkg::OUT_W-1:0]              m_heading_centideg
);
    import chc_pkg::*;

    localparam int NUM_STAGES = (ANGLE_ITERATIONS < ATAN_TABLE_LEN)
                              ? ANGLE_ITERATIONS : ATAN_TABLE_LEN;

    logic        stg_valid [NUM_STAGES+1];
    logic        stg_ready [NUM_STAGES+1];
    chc_vec_t    stg_vec   [NUM_STAGES+1];
    chc_flags_t  stg_flags [NUM_STAGES+1];

    chc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_field   (s_x_field),
        .y_field   (s_y_field),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_vec   (stg_vec[0]),
        .out_flags (stg_flags[0])
    );

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cordic
        chc_cordic_stage #(
            .STAGE_IDX (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_vec    (stg_vec[g]),
            .in_flags  (stg_flags[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_vec   (stg_vec[g+1]),
            .out_flags (stg_flags[g+1])
        );
    end

    chc_post u_post (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (stg_valid[NUM_STAGES]),
        .in_ready         (stg_ready[NUM_STAGES]),
        .in_vec           (stg_vec[NUM_STAGES]),
        .in_flags         (stg_flags[NUM_STAGES]),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .heading_centideg (m_heading_centideg)
    );

endmodule

`default_nettype wire
